[hw/rtl/kar_pkg.sv]
// Shared types and constants for the key auto-repeat event generator.
package kar_pkg;

    localparam int KEY_W   = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int ENA_W   = 3;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEATS_PER_FAST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ENABLE    = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_INITIAL_DELAY   = 16'd500;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 16'd100;
    localparam logic [CFG_W-1:0] RST_REPEATS_PER_FAST = 16'd20;
    localparam logic [ENA_W-1:0] RST_EVENT_ENABLE    = 3'b111;

    // Event enable bit positions
    localparam int ENA_DOWN  = 0;
    localparam int ENA_PRESS = 1;
    localparam int ENA_UP    = 2;

    typedef struct packed {
        logic [CFG_W-1:0] initial_delay;
        logic [CFG_W-1:0] repeat_interval;
        logic [CFG_W-1:0] repeats_per_fast_step;
        logic [ENA_W-1:0] event_enable;
    } t_cfg;

    typedef struct packed {
        logic              held;
        logic [KEY_W-1:0]  last_key;
        logic [TIME_W-1:0] deadline;
        logic [CFG_W-1:0]  repeats_left;
        logic [CFG_W-1:0]  fast_count;
    } t_state;

    typedef struct packed {
        logic              down_event;
        logic              press_event;
        logic              up_event;
        logic [KEY_W-1:0]  event_key;
        logic [CFG_W-1:0]  fast_level;
    } t_result;

endpackage

[hw/rtl/kar_step.sv]
// Next-state and event logic for one key poll.
module kar_step (
    input  kar_pkg::t_cfg                   i_cfg,
    input  kar_pkg::t_state                 i_state,
    input  logic [kar_pkg::KEY_W-1:0]       i_key,
    input  logic [kar_pkg::TIME_W-1:0]      i_now,
    output kar_pkg::t_state                 o_state,
    output kar_pkg::t_result                o_result
);
    import kar_pkg::*;

    logic             dn;
    logic             pr;
    logic             up;
    logic [KEY_W-1:0] ekey;
    logic             key_nz;
    logic             prev_nz;

    assign key_nz  = (i_key != '0);
    assign prev_nz = (i_state.last_key != '0);

    always_comb begin
        o_state          = i_state;
        o_state.last_key = i_key;
        dn   = 1'b0;
        pr   = 1'b0;
        up   = 1'b0;
        ekey = '0;

        if (!i_state.held) begin
            o_state.repeats_left = i_cfg.repeats_per_fast_step;
            o_state.fast_count   = '0;
            if (!prev_nz && key_nz) begin
                dn               = 1'b1;
                pr               = 1'b1;
                ekey             = i_key;
                o_state.deadline = i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.initial_delay};
                o_state.held     = 1'b1;
            end
        end else if (prev_nz && !key_nz) begin
            up           = 1'b1;
            ekey         = i_state.last_key;
            o_state.held = 1'b0;
        end else if (i_now > i_state.deadline) begin
            o_state.deadline = i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_interval};
            pr               = 1'b1;
            ekey             = i_key;
            if (i_state.repeats_left != '0) begin
                o_state.repeats_left = i_state.repeats_left - 1'b1;
            end else begin
                o_state.repeats_left = i_cfg.repeats_per_fast_step;
                if (i_state.fast_count != '1) begin
                    o_state.fast_count = i_state.fast_count + 1'b1;
                end
            end
        end

        // disabled events keep their state effects but are not flagged
        o_result.down_event  = dn & i_cfg.event_enable[ENA_DOWN];
        o_result.press_event = pr & i_cfg.event_enable[ENA_PRESS];
        o_result.up_event    = up & i_cfg.event_enable[ENA_UP];
        o_result.event_key   = (o_result.down_event | o_result.press_event |
                                o_result.up_event) ? ekey : '0;
        o_result.fast_level  = o_state.fast_count;
    end

endmodule

[hw/rtl/key_autorepeat_event_generator_core.sv]
// Top level: typematic key auto-repeat event generator.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-------------------------------------------
//  in      | i_in_valid   | o_in_stall   | i_key_code, i_now_time
//  out     | o_out_valid  | i_out_stall  | o_down_event, o_press_event, o_up_event,
//          |              |              | o_event_key, o_fast_level
//  cfg     | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_wdata
//
// One item per cycle sustained while the output is not stalled; an accepted item passes
// through the input register, then the step logic into the result register, to o_out_valid.
// The poll state (held flag, last key, deadline, repeat counters) updates as an
// item moves from the input register into the result register, so back-to-back
// items see each other's effects in order.
// Synchronous active-low reset clears control state and loads the register defaults.
// A stall on the output backs up into o_in_stall only once both stages are full.
module key_autorepeat_event_generator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [kar_pkg::KEY_W-1:0]         i_key_code,
    input  logic [kar_pkg::TIME_W-1:0]        i_now_time,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_down_event,
    output logic                              o_press_event,
    output logic                              o_up_event,
    output logic [kar_pkg::KEY_W-1:0]         o_event_key,
    output logic [kar_pkg::CFG_W-1:0]         o_fast_level,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [kar_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kar_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import kar_pkg::*;

    // config registers
    t_cfg              r_cfg;

    // input stage
    logic              r_s1_valid;
    logic [KEY_W-1:0]  r_s1_key;
    logic [TIME_W-1:0] r_s1_now;

    // poll state
    t_state            r_state;
    t_state            n_state;

    // result stage
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              s1_adv;
    logic              in_acc;

    // s1 moves on when the result register is empty or being drained
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay         <= RST_INITIAL_DELAY;
            r_cfg.repeat_interval       <= RST_REPEAT_INTERVAL;
            r_cfg.repeats_per_fast_step <= RST_REPEATS_PER_FAST;
            r_cfg.event_enable          <= RST_EVENT_ENABLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INITIAL_DELAY:    r_cfg.initial_delay         <= i_cfg_wdata;
                CFG_REPEAT_INTERVAL:  r_cfg.repeat_interval       <= i_cfg_wdata;
                CFG_REPEATS_PER_FAST: r_cfg.repeats_per_fast_step <= i_cfg_wdata;
                CFG_EVENT_ENABLE:     r_cfg.event_enable          <= i_cfg_wdata[ENA_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_key <= i_key_code;
            r_s1_now <= i_now_time;
        end
    end

    kar_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_key    (r_s1_key),
        .i_now    (r_s1_now),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // poll state commits with the item it belongs to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_down_event  = r_out.down_event;
    assign o_press_event = r_out.press_event;
    assign o_up_event    = r_out.up_event;
    assign o_event_key   = r_out.event_key;
    assign o_fast_level  = r_out.fast_level;

`ifndef NO_ASSERTIONS
    // an up event never shares a result with down or press
    a_up_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_up_event && (o_down_event || o_press_event)))
        else $error("up event combined with down/press");

    // no flagged event means a zero key
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_down_event && !o_press_event && !o_up_event)
            |-> (o_event_key == '0))
        else $error("event key set without an event");

    // a down event only comes from idle, where the fast level is cleared
    a_down_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_down_event) |-> (o_fast_level == '0))
        else $error("down event with nonzero fast level");

    // an item leaving the input stage lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("item lost between stages");
`endif

endmodule

[tb/tb_key_autorepeat_event_generator_core.sv]
// Self-checking testbench for the key auto-repeat event generator core.
`timescale 1ns / 1ps

module tb_key_autorepeat_event_generator_core;
    import kar_pkg::*;

    localparam int RUN_LIMIT    = 1_500_000;   // cycles
    localparam int DRAIN_CYCLES = 4;           // two-stage pipe plus margin
    localparam int PHASES       = 8;
    localparam int PHASE_POLLS  = 230;
    localparam int FAST_POLLS   = 40;

    // Poll tracker: mirrors the held/idle state, the repeat deadline and the
    // fast-level counters, and queues one expected event item per poll.
    class event_board;
        t_cfg             regs;
        logic             armed;
        logic [KEY_W-1:0] seen_key;
        logic [TIME_W-1:0] deadline;
        logic [CFG_W-1:0] repeats_left;
        logic [CFG_W-1:0] fast;
        t_result          pending_events[$];
        int               error_count;

        function new();
            regs.initial_delay         = RST_INITIAL_DELAY;
            regs.repeat_interval       = RST_REPEAT_INTERVAL;
            regs.repeats_per_fast_step = RST_REPEATS_PER_FAST;
            regs.event_enable          = RST_EVENT_ENABLE;
            armed        = 1'b0;
            seen_key     = '0;
            deadline     = '0;
            repeats_left = '0;
            fast         = '0;
            error_count  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_INITIAL_DELAY:    regs.initial_delay = data;
                CFG_REPEAT_INTERVAL:  regs.repeat_interval = data;
                CFG_REPEATS_PER_FAST: regs.repeats_per_fast_step = data;
                CFG_EVENT_ENABLE:     regs.event_enable = data[ENA_W-1:0];
                default: ;
            endcase
        endfunction

        function t_result step_poll(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
            t_result          r;
            logic [KEY_W-1:0] prev;
            logic             dn, pr, up;
            logic [KEY_W-1:0] ek;
            prev = seen_key;
            seen_key = key;
            dn = 1'b0;
            pr = 1'b0;
            up = 1'b0;
            ek = '0;
            if (!armed) begin
                // idle polls reload the repeat count and clear the fast level
                repeats_left = regs.repeats_per_fast_step;
                fast = '0;
                if (prev == '0 && key != '0) begin
                    dn = 1'b1;
                    pr = 1'b1;
                    ek = key;
                    deadline = now + {16'h0, regs.initial_delay};   // wraps mod 2^32
                    armed = 1'b1;
                end
            end else begin
                if (prev != '0 && key == '0) begin
                    up = 1'b1;
                    ek = prev;
                    armed = 1'b0;
                end else if (now > deadline) begin
                    deadline = now + {16'h0, regs.repeat_interval};
                    pr = 1'b1;
                    ek = key;
                    if (repeats_left != '0) begin
                        repeats_left = repeats_left - 1'b1;
                    end else begin
                        repeats_left = regs.repeats_per_fast_step;
                        if (fast != 16'hFFFF) fast = fast + 1'b1;
                    end
                end
            end
            // disabled events keep their state effects but are not flagged
            dn = dn & regs.event_enable[ENA_DOWN];
            pr = pr & regs.event_enable[ENA_PRESS];
            up = up & regs.event_enable[ENA_UP];
            if (!dn && !pr && !up) ek = '0;
            r.down_event  = dn;
            r.press_event = pr;
            r.up_event    = up;
            r.event_key   = ek;
            r.fast_level  = fast;
            return r;
        endfunction

        function void note_poll(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
            pending_events.push_back(step_poll(key, now));
        endfunction

        function void check_event(t_result got);
            t_result exp;
            if (pending_events.size() == 0) begin
                $error("event item with none pending: %0h", got);
                error_count++;
                return;
            end
            exp = pending_events.pop_front();
            if (got.down_event !== exp.down_event) begin
                $error("down_event: expected %0d, got %0d", exp.down_event, got.down_event);
                error_count++;
            end
            if (got.press_event !== exp.press_event) begin
                $error("press_event: expected %0d, got %0d", exp.press_event, got.press_event);
                error_count++;
            end
            if (got.up_event !== exp.up_event) begin
                $error("up_event: expected %0d, got %0d", exp.up_event, got.up_event);
                error_count++;
            end
            if (got.event_key !== exp.event_key) begin
                $error("event_key: expected %0h, got %0h", exp.event_key, got.event_key);
                error_count++;
            end
            if (got.fast_level !== exp.fast_level) begin
                $error("fast_level: expected %0d, got %0d", exp.fast_level, got.fast_level);
                error_count++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KEY_W-1:0]      i_key_code;
    logic [TIME_W-1:0]     i_now_time;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_down_event;
    logic                  o_press_event;
    logic                  o_up_event;
    logic [KEY_W-1:0]      o_event_key;
    logic [CFG_W-1:0]      o_fast_level;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_wdata;

    event_board        board;
    int                accepted_polls = 0;
    int                cycle_count = 0;
    bit                idle_on = 1'b1;      // 0: both sides run flat out
    bit                hold_request = 1'b0; // asks the receiver for one long hold-off
    logic [TIME_W-1:0] poll_clock = '0;     // free-running time seen by the block

    key_autorepeat_event_generator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_key_code    (i_key_code),
        .i_now_time    (i_now_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_down_event  (o_down_event),
        .o_press_event (o_press_event),
        .o_up_event    (o_up_event),
        .o_event_key   (o_event_key),
        .o_fast_level  (o_fast_level),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_key_autorepeat_event_generator_core: done, errors");
            $finish;
        end
    end

    // Sender gap: mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one poll and hold it until accepted. Called at a rising edge;
    // valid stays high into the next call unless that call opens a gap.
    task automatic send_poll(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key_code <= key;
        i_now_time <= now;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.note_poll(key, now);
        accepted_polls++;
    endtask

    // Drop valid, let every pending event item come out, then settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; block must be idle.
    task automatic program_regs(logic [CFG_W-1:0] delay, logic [CFG_W-1:0] interval,
                                logic [CFG_W-1:0] per_step, logic [CFG_W-1:0] enables);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_INITIAL_DELAY;
        i_cfg_wdata <= delay;
        @(posedge i_clk);
        board.set_reg(CFG_INITIAL_DELAY, delay);
        i_cfg_idx   <= CFG_REPEAT_INTERVAL;
        i_cfg_wdata <= interval;
        @(posedge i_clk);
        board.set_reg(CFG_REPEAT_INTERVAL, interval);
        i_cfg_idx   <= CFG_REPEATS_PER_FAST;
        i_cfg_wdata <= per_step;
        @(posedge i_clk);
        board.set_reg(CFG_REPEATS_PER_FAST, per_step);
        i_cfg_idx   <= CFG_EVENT_ENABLE;
        i_cfg_wdata <= enables;
        @(posedge i_clk);
        board.set_reg(CFG_EVENT_ENABLE, enables);
        i_cfg_we    <= 1'b0;
    endtask

    // Random polls. Mostly clean press/hold/release runs with random keys and time
    // steps, some after a time jump or near-wrap; the rest is noise of random keys.
    task automatic run_random_polls(int count, int step_max);
        int               target;
        int               r;
        int               hold;
        logic [KEY_W-1:0] key;
        target = accepted_polls + count;
        while (accepted_polls < target) begin
            r = $urandom_range(0, 99);
            if (r < 3) poll_clock = $urandom();
            else if (r < 6) poll_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
            if (r < 75) begin
                key = KEY_W'($urandom_range(1, 255));
                hold = $urandom_range(1, 30);
                for (int k = 0; k < hold; k++) begin
                    // occasional key change while held: no up, repeats take the new key
                    if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom_range(1, 255));
                    send_poll(key, poll_clock);
                    poll_clock = poll_clock + $urandom_range(0, step_max);
                end
                repeat ($urandom_range(1, 3)) begin
                    send_poll('0, poll_clock);
                    poll_clock = poll_clock + $urandom_range(0, step_max);
                end
            end else begin
                key = ($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom_range(0, 255));
                send_poll(key, ($urandom_range(0, 4) == 0) ? $urandom() : poll_clock);
                poll_clock = poll_clock + $urandom_range(0, step_max);
            end
        end
    endtask

    // Receiver: checks accepted event items and drives the output stall.
    initial begin
        int stall_left;
        int hold_left;
        int r;
        stall_left = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
                board.check_event({o_down_event, o_press_event, o_up_event,
                                   o_event_key, o_fast_level});
            if (hold_request) begin
                hold_left = 300;      // long enough for both stages to fill
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!idle_on) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_out_stall <= 1'b0;
                end else if (r < 96) begin
                    stall_left = $urandom_range(0, 2);
                    i_out_stall <= 1'b1;
                end else begin
                    stall_left = $urandom_range(10, 50);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    // Main sequence
    initial begin
        logic [CFG_W-1:0] en_word;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_key_code  <= '0;
        i_now_time  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_INITIAL_DELAY;
        i_cfg_wdata <= '0;
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset register values (delay 500, interval 100)
        send_poll(8'h00, 32'd0);              // no event
        send_poll(8'hFF, 32'd10);             // down + press, deadline 510
        send_poll(8'hFF, 32'd510);            // equal to deadline: nothing
        send_poll(8'hFF, 32'd511);            // first repeat
        send_poll(8'h11, 32'd700);            // key change while held
        send_poll(8'h00, 32'd705);            // up carries previous key
        send_poll(8'h00, 32'hFFFF_FFFF);
        send_poll(8'h01, 32'hFFFF_FF00);      // deadline sum wraps to 0xF4
        send_poll(8'h01, 32'h0000_0000);      // plain compare, no repeat
        send_poll(8'h01, 32'h0000_0100);      // past the wrapped deadline
        send_poll(8'h00, 32'h0000_0200);
        wait_drained();

        // All events disabled, zero delay and interval, fast step every repeat
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_poll(8'h80, 32'd5);
        send_poll(8'h80, 32'd6);              // repeat: fast level 1, deadline = now
        send_poll(8'h80, 32'd6);
        send_poll(8'h80, 32'd7);
        send_poll(8'h00, 32'd8);
        wait_drained();

        // Register maxima, down and up only
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFF5);
        send_poll(8'h55, 32'hFFFF_0000);      // deadline lands on 0xFFFFFFFF
        send_poll(8'h55, 32'hFFFF_FFFF);
        send_poll(8'h00, 32'h0000_0020);
        wait_drained();

        // Fast level climb: a repeat on every poll after the down, one step per repeat
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0007);
        idle_on = 1'b0;
        for (int t = 0; t < FAST_POLLS; t++) send_poll(8'h3C, 32'd1000 + t);
        send_poll(8'h00, 32'd70000);
        send_poll(8'h00, 32'd70001);          // idle poll clears the level
        wait_drained();

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++) begin
            en_word = {13'($urandom()),
                       ($urandom_range(0, 9) < 6) ? 3'b111 : 3'($urandom_range(0, 6))};
            case (p)
                0: program_regs(16'h0000, 16'h0000, 16'h0000, en_word);
                1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: program_regs(CFG_W'($urandom_range(0, 60)),
                                      CFG_W'($urandom_range(0, 15)),
                                      CFG_W'($urandom_range(0, 4)), en_word);
            endcase
            idle_on = (p != 4);
            if (p == 2) hold_request = 1'b1;
            run_random_polls(PHASE_POLLS, (p == 1) ? 40000 : ((p == 0) ? 3 : 24));
            wait_drained();
        end

        if (board.error_count == 0 && board.pending_events.size() == 0) begin
            $display("tb_key_autorepeat_event_generator_core: done, clean");
        end else begin
            $display("tb_key_autorepeat_event_generator_core: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kar_pkg.sv
hw/rtl/kar_step.sv
hw/rtl/key_autorepeat_event_generator_core.sv
tb/tb_key_autorepeat_event_generator_core.sv
